FILE: hw/rtl/fwsr_pkg.sv
// fwsr_pkg: sizes, types, action and status codes and small helpers for the
// queue with swap, reverse and search
// depends on nothing; every other file of the block imports it
`default_nettype none

package fwsr_pkg;

    // queue geometry
    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;

    // widths derived from the geometry
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // fixed widths of the channel fields
    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;
    localparam int FIELD_W  = 32;

    typedef logic [PTR_W-1:0]      ptr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [VALUE_BITS-1:0] word_t;

    localparam ptr_t PTR_LAST = PTR_W'(DEPTH - 1);
    localparam cnt_t CNT_FULL = CNT_W'(DEPTH);

    // action codes
    localparam logic [ACTION_W-1:0] ACT_ENQ    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DEQ    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_SWAP   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_REV    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_SEARCH = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FEW   = 2'd3;

    // one access to the ring store: a read request and a write request
    typedef struct packed {
        logic  rd_en;
        ptr_t  rd_addr;
        logic  wr_en;
        ptr_t  wr_addr;
        word_t wr_data;
    } mem_cmd_t;

    // ring index a + b, both below DEPTH
    function automatic ptr_t wrap_add(ptr_t a, ptr_t b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PTR_W + 1)'(DEPTH))
        begin
            s = s - (PTR_W + 1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    // sign-extend the request word, keep VALUE_BITS of it
    function automatic word_t to_word(logic signed [FIELD_W-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return w[VALUE_BITS-1:0];
    endfunction

    // stored word as it leaves on the result channel
    function automatic logic [FIELD_W-1:0] to_field(word_t w);
        logic [63:0] x;
        x = 64'(w);
        return x[FIELD_W-1:0];
    endfunction

    // entry count as it leaves on the result channel
    function automatic logic [COUNT_W-1:0] to_count(cnt_t c);
        logic [63:0] x;
        x = 64'(c);
        return x[COUNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fwsr_cmd_if.sv
// fwsr_cmd_if: request channel of the queue, valid/ready with action and value
// depends on fwsr_pkg
`default_nettype none

interface fwsr_cmd_if import fwsr_pkg::*; ();

    logic                        valid;
    logic                        ready;
    logic [ACTION_W-1:0]         action;
    logic signed [FIELD_W-1:0]   value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);

endinterface

`default_nettype wire

FILE: hw/rtl/fwsr_rsp_if.sv
// fwsr_rsp_if: result channel of the queue, valid/ready with status, found,
// count and removed value; depends on fwsr_pkg
`default_nettype none

interface fwsr_rsp_if import fwsr_pkg::*; ();

    logic                        valid;
    logic                        ready;
    logic [STATUS_W-1:0]         status;
    logic                        found;
    logic [COUNT_W-1:0]          count;
    logic signed [FIELD_W-1:0]   removed_value;

    modport source (output valid, output status, output found, output count,
                    output removed_value, input ready);
    modport sink   (input valid, input status, input found, input count,
                    input removed_value, output ready);

endinterface

`default_nettype wire

FILE: hw/rtl/fwsr_store.sv
// fwsr_store: ring store of the queue, one write and one registered read a
// cycle, plus the shared equality compare on the read word; uses fwsr_pkg
`default_nettype none

module fwsr_store import fwsr_pkg::*;
(
    input  wire logic     clk,
    input  wire mem_cmd_t mem_cmd,
    input  wire word_t    key,
    output word_t         rd_data,
    output logic          match
);

    word_t mem [DEPTH];
    word_t rd_data_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (mem_cmd.wr_en)
        begin
            mem[mem_cmd.wr_addr] <= mem_cmd.wr_data;
        end
        if (mem_cmd.rd_en)
        begin
            rd_data_reg <= mem[mem_cmd.rd_addr];
        end
    end

    // shared compare against the search key
    assign rd_data = rd_data_reg;
    assign match   = (rd_data_reg == key);

endmodule

`default_nettype wire

FILE: hw/rtl/fwsr_ctrl.sv
// fwsr_ctrl: sequencer of the queue: pointers, direction flag, the steps of
// each action and the result register; uses fwsr_pkg and both channel interfaces
`default_nettype none

module fwsr_ctrl import fwsr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fwsr_cmd_if.sink   cmd,
    fwsr_rsp_if.source rsp,
    output mem_cmd_t   mem_cmd,
    output word_t      key,
    input  wire word_t rd_data,
    input  wire logic  match
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEQ,
        S_SWAP_RD,
        S_SWAP_WP,
        S_SWAP_WQ,
        S_SEARCH,
        S_HOLD
    } state_t;

    state_t              state_reg, state_next;
    ptr_t                front_reg, front_next;
    cnt_t                fill_reg, fill_next;
    logic                flip_reg, flip_next;
    word_t               word_reg, word_next;
    ptr_t                addr_reg, addr_next;
    ptr_t                other_reg, other_next;
    cnt_t                left_reg, left_next;
    word_t               tmp_reg, tmp_next;
    logic [STATUS_W-1:0] hold_status_reg, hold_status_next;
    logic                hold_found_reg, hold_found_next;
    logic [FIELD_W-1:0]  hold_removed_reg, hold_removed_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_found_reg, out_found_next;
    logic [COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [FIELD_W-1:0]  out_removed_reg, out_removed_next;

    logic                fin;
    logic [STATUS_W-1:0] fin_status;
    logic                fin_found;
    logic [FIELD_W-1:0]  fin_removed;
    logic                out_free;
    ptr_t                back_ptr;
    word_t               in_word;

    // physical slot of the last entry
    assign back_ptr = wrap_add(front_reg, PTR_W'(fill_reg - cnt_t'(1)));
    assign in_word  = to_word(cmd.value);
    assign out_free = !out_valid_reg || rsp.ready;

    // channel outputs
    assign cmd.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.found         = out_found_reg;
    assign rsp.count         = out_count_reg;
    assign rsp.removed_value = out_removed_reg;
    assign key               = word_reg;

    // sequencer
    always_comb
    begin
        state_next        = state_reg;
        front_next        = front_reg;
        fill_next         = fill_reg;
        flip_next         = flip_reg;
        word_next         = word_reg;
        addr_next         = addr_reg;
        other_next        = other_reg;
        left_next         = left_reg;
        tmp_next          = tmp_reg;
        hold_status_next  = hold_status_reg;
        hold_found_next   = hold_found_reg;
        hold_removed_next = hold_removed_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        out_status_next   = out_status_reg;
        out_found_next    = out_found_reg;
        out_count_next    = out_count_reg;
        out_removed_next  = out_removed_reg;
        mem_cmd           = '0;
        fin               = 1'b0;
        fin_status        = ST_OK;
        fin_found         = 1'b0;
        fin_removed       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    word_next = in_word;
                    unique case (cmd.action)
                        ACT_ENQ:
                        begin
                            fin = 1'b1;
                            if (fill_reg == CNT_FULL)
                            begin
                                fin_status = ST_FULL;
                            end
                            else
                            begin
                                mem_cmd.wr_en   = 1'b1;
                                mem_cmd.wr_data = in_word;
                                fill_next       = fill_reg + cnt_t'(1);
                                if (!flip_reg)
                                begin
                                    mem_cmd.wr_addr = wrap_add(front_reg, PTR_W'(fill_reg));
                                end
                                else
                                begin
                                    front_next      = wrap_add(front_reg, PTR_LAST);
                                    mem_cmd.wr_addr = wrap_add(front_reg, PTR_LAST);
                                end
                            end
                        end
                        ACT_DEQ:
                        begin
                            if (fill_reg == '0)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_EMPTY;
                            end
                            else
                            begin
                                mem_cmd.rd_en   = 1'b1;
                                mem_cmd.rd_addr = flip_reg ? back_ptr : front_reg;
                                fill_next       = fill_reg - cnt_t'(1);
                                if (!flip_reg)
                                begin
                                    front_next = wrap_add(front_reg, ptr_t'(1));
                                end
                                state_next = S_DEQ;
                            end
                        end
                        ACT_SWAP:
                        begin
                            if (fill_reg < cnt_t'(2))
                            begin
                                fin        = 1'b1;
                                fin_status = ST_FEW;
                            end
                            else
                            begin
                                mem_cmd.rd_en   = 1'b1;
                                mem_cmd.rd_addr = front_reg;
                                addr_next       = front_reg;
                                other_next      = back_ptr;
                                state_next      = S_SWAP_RD;
                            end
                        end
                        ACT_REV:
                        begin
                            fin       = 1'b1;
                            flip_next = !flip_reg;
                        end
                        ACT_SEARCH:
                        begin
                            if (fill_reg == '0)
                            begin
                                fin = 1'b1;
                            end
                            else
                            begin
                                mem_cmd.rd_en   = 1'b1;
                                mem_cmd.rd_addr = front_reg;
                                addr_next       = wrap_add(front_reg, ptr_t'(1));
                                left_next       = fill_reg - cnt_t'(1);
                                state_next      = S_SEARCH;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            fin        = 1'b1;
                            fill_next  = '0;
                            front_next = '0;
                            flip_next  = 1'b0;
                        end
                        default:
                        begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_DEQ:
            begin
                fin         = 1'b1;
                fin_removed = to_field(rd_data);
            end
            S_SWAP_RD:
            begin
                // first word parked, last word requested
                tmp_next        = rd_data;
                mem_cmd.rd_en   = 1'b1;
                mem_cmd.rd_addr = other_reg;
                state_next      = S_SWAP_WP;
            end
            S_SWAP_WP:
            begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = addr_reg;
                mem_cmd.wr_data = rd_data;
                state_next      = S_SWAP_WQ;
            end
            S_SWAP_WQ:
            begin
                mem_cmd.wr_en   = 1'b1;
                mem_cmd.wr_addr = other_reg;
                mem_cmd.wr_data = tmp_reg;
                fin             = 1'b1;
            end
            S_SEARCH:
            begin
                // compare the word read last cycle, request the next one
                if (match)
                begin
                    fin       = 1'b1;
                    fin_found = 1'b1;
                end
                else if (left_reg != '0)
                begin
                    mem_cmd.rd_en   = 1'b1;
                    mem_cmd.rd_addr = addr_reg;
                    addr_next       = wrap_add(addr_reg, ptr_t'(1));
                    left_next       = left_reg - cnt_t'(1);
                end
                else
                begin
                    fin = 1'b1;
                end
            end
            S_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = hold_status_reg;
                    out_found_next   = hold_found_reg;
                    out_count_next   = to_count(fill_reg);
                    out_removed_next = hold_removed_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // result goes to the output register, or waits in the hold registers until that is free
        if (fin)
        begin
            if (out_free)
            begin
                out_valid_next   = 1'b1;
                out_status_next  = fin_status;
                out_found_next   = fin_found;
                out_count_next   = to_count(fill_next);
                out_removed_next = fin_removed;
                state_next       = S_IDLE;
            end
            else
            begin
                hold_status_next  = fin_status;
                hold_found_next   = fin_found;
                hold_removed_next = fin_removed;
                state_next        = S_HOLD;
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            front_reg        <= '0;
            fill_reg         <= '0;
            flip_reg         <= 1'b0;
            word_reg         <= '0;
            addr_reg         <= '0;
            other_reg        <= '0;
            left_reg         <= '0;
            tmp_reg          <= '0;
            hold_status_reg  <= ST_OK;
            hold_found_reg   <= 1'b0;
            hold_removed_reg <= '0;
            out_valid_reg    <= 1'b0;
            out_status_reg   <= ST_OK;
            out_found_reg    <= 1'b0;
            out_count_reg    <= '0;
            out_removed_reg  <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            front_reg        <= front_next;
            fill_reg         <= fill_next;
            flip_reg         <= flip_next;
            word_reg         <= word_next;
            addr_reg         <= addr_next;
            other_reg        <= other_next;
            left_reg         <= left_next;
            tmp_reg          <= tmp_next;
            hold_status_reg  <= hold_status_next;
            hold_found_reg   <= hold_found_next;
            hold_removed_reg <= hold_removed_next;
            out_valid_reg    <= out_valid_next;
            out_status_reg   <= out_status_next;
            out_found_reg    <= out_found_next;
            out_count_reg    <= out_count_next;
            out_removed_reg  <= out_removed_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fifo_with_swap_reverse_search.sv
// fifo_with_swap_reverse_search: top level of the bounded queue of signed words
// instantiates fwsr_ctrl and fwsr_store; uses fwsr_pkg, fwsr_cmd_if, fwsr_rsp_if
//
// A bounded queue of DEPTH signed words in a ring store, driven by one request
// per action: enqueue, dequeue, swap first and last, reverse, search, clear.
// Each request gives exactly one result with status, found flag, count after
// the action and the dequeued word. Reverse only flips which end is the
// front, so it costs no data movement. The store has one write port and one
// registered read port, and one comparator serves the search. Enqueue,
// reverse, clear, unknown actions and every error finish in the idle state
// that takes them; dequeue first reads its word; swap reads the first word,
// then the last, and writes each into the other's slot; search compares the
// entries in turn from the front (at most the count, stopping at the first
// hit). The request channel is not ready while an action is in progress; a
// finished result sits in the output register and the next request is taken
// while it waits. There is no clearing pass after reset; stored words are only read once written.
`default_nettype none

module fifo_with_swap_reverse_search import fwsr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    fwsr_cmd_if.sink   cmd,
    fwsr_rsp_if.source rsp
);

    mem_cmd_t mem_cmd;
    word_t    key;
    word_t    rd_data;
    logic     match;

    // sequencer and result register
    fwsr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .rsp     (rsp),
        .mem_cmd (mem_cmd),
        .key     (key),
        .rd_data (rd_data),
        .match   (match)
    );

    // ring store with the shared comparator
    fwsr_store u_store (
        .clk     (clk),
        .mem_cmd (mem_cmd),
        .key     (key),
        .rd_data (rd_data),
        .match   (match)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/fwsr_check.sv
// fwsr_check: port-level checks on the queue's results, bound to the top level
// uses fwsr_pkg
`default_nettype none

module fwsr_check import fwsr_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      rsp_valid,
    input wire logic                      rsp_ready,
    input wire logic [STATUS_W-1:0]       rsp_status,
    input wire logic                      rsp_found,
    input wire logic [COUNT_W-1:0]        rsp_count,
    input wire logic signed [FIELD_W-1:0] rsp_removed_value
);

    // a refused enqueue only happens on a full queue
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FULL |-> rsp_count == COUNT_W'(DEPTH))
        else $error("full status with a count short of depth");

    // a refused dequeue leaves an empty queue and no word
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0 && rsp_removed_value == '0)
        else $error("empty status with entries or a removed word");

    // a refused swap means fewer than two entries
    a_few: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status == ST_FEW |-> rsp_count < COUNT_W'(2))
        else $error("swap refused with two or more entries");

    // a hit is never an error and never carries a removed word
    a_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_found |-> rsp_status == ST_OK && rsp_removed_value == '0)
        else $error("found flag with error status or removed word");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid
            && $stable({rsp_status, rsp_found, rsp_count, rsp_removed_value}))
        else $error("result changed while stalled");

endmodule

bind fifo_with_swap_reverse_search fwsr_check u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_found         (rsp.found),
    .rsp_count         (rsp.count),
    .rsp_removed_value (rsp.removed_value)
);

`default_nettype wire

FILE: verif/fwsr_scoreboard.sv
// fwsr_scoreboard: watches the request and result channels of the queue, keeps its own copy
// of the queue state and compares every result with the predicted one
// depends on fwsr_pkg, fwsr_cmd_if and fwsr_rsp_if
`default_nettype none

module fwsr_scoreboard import fwsr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic drain_done,
    fwsr_cmd_if       cmd,
    fwsr_rsp_if       rsp,
    output int        fail_count,
    output int        outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [COUNT_W-1:0]  count;
        logic [FIELD_W-1:0]  removed_value;
    } outcome_t;

    // shadow copy of the ring
    word_t       ring [DEPTH];
    int unsigned head;
    int unsigned fill;
    bit          flipped;

    outcome_t pending_outcomes [$];

    initial
    begin
        fail_count  = 0;
        outstanding = 0;
    end

    // count a failure, print only the first few
    task automatic report_fault(string detail);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("[%0t ns] %s", $time, detail);
        end
    endtask

    // apply one request to the shadow queue and return the result it should give
    function automatic outcome_t queue_outcome(logic [ACTION_W-1:0] act,
                                               logic signed [FIELD_W-1:0] val);
        outcome_t         res;
        logic signed [63:0] ext;
        logic [63:0]      wide;
        word_t            w;
        word_t            tmp;
        int unsigned      tail;
        res  = '0;
        ext  = val;
        w    = ext[VALUE_BITS-1:0];
        tail = (head + fill + DEPTH - 1) % DEPTH;
        case (act)
            ACT_ENQ:
            begin
                if (fill >= DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else if (!flipped)
                begin
                    ring[(head + fill) % DEPTH] = w;
                    fill++;
                end
                else
                begin
                    head = (head + DEPTH - 1) % DEPTH;
                    ring[head] = w;
                    fill++;
                end
            end
            ACT_DEQ:
            begin
                if (fill == 0)
                begin
                    res.status = ST_EMPTY;
                end
                else
                begin
                    wide = '0;
                    if (!flipped)
                    begin
                        wide[VALUE_BITS-1:0] = ring[head];
                        head = (head + 1) % DEPTH;
                    end
                    else
                    begin
                        wide[VALUE_BITS-1:0] = ring[tail];
                    end
                    fill--;
                    res.removed_value = wide[FIELD_W-1:0];
                end
            end
            ACT_SWAP:
            begin
                if (fill < 2)
                begin
                    res.status = ST_FEW;
                end
                else
                begin
                    tmp        = ring[head];
                    ring[head] = ring[tail];
                    ring[tail] = tmp;
                end
            end
            ACT_REV:
            begin
                flipped = !flipped;
            end
            ACT_SEARCH:
            begin
                for (int unsigned i = 0; i < fill; i++)
                begin
                    if (ring[(head + i) % DEPTH] == w)
                    begin
                        res.found = 1'b1;
                    end
                end
            end
            ACT_CLEAR:
            begin
                fill    = 0;
                head    = 0;
                flipped = 1'b0;
            end
            default:
            begin
            end
        endcase
        res.count = fill[COUNT_W-1:0];
        return res;
    endfunction

    // results are checked before the request of the same edge is predicted
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                ring[i] = '0;
            end
            head    = 0;
            fill    = 0;
            flipped = 1'b0;
            pending_outcomes.delete();
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got.status        = rsp.status;
                got.found         = rsp.found;
                got.count         = rsp.count;
                got.removed_value = rsp.removed_value;
                if (pending_outcomes.size() == 0)
                begin
                    report_fault($sformatf(
                        "unexpected result: status %0d found %0b count %0d removed %0d",
                        got.status, got.found, got.count, $signed(got.removed_value)));
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (got.status !== want.status || got.found !== want.found ||
                        got.count !== want.count ||
                        got.removed_value !== want.removed_value)
                    begin
                        report_fault($sformatf({"result mismatch: expected status %0d ",
                            "found %0b count %0d removed %0d, got status %0d found %0b ",
                            "count %0d removed %0d"},
                            want.status, want.found, want.count,
                            $signed(want.removed_value), got.status, got.found,
                            got.count, $signed(got.removed_value)));
                    end
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                pending_outcomes.push_back(queue_outcome(cmd.action, cmd.value));
            end
        end
        outstanding = pending_outcomes.size();
    end

    // results still owed once the run has drained
    always @(posedge drain_done)
    begin
        if (pending_outcomes.size() != 0)
        begin
            report_fault($sformatf("%0d results never arrived", pending_outcomes.size()));
        end
    end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// testbench: drives requests into the queue with swap, reverse and search, stalls the
// result side and gives the verdict; depends on fwsr_pkg, both channel interfaces,
// fwsr_scoreboard and the block itself
`default_nettype none

module testbench import fwsr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // action codes the block treats as no-ops
    localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
    localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic drain_done = 1'b0;

    int fail_count;
    int outstanding;

    // idling controls and the long result-side stall
    bit send_gaps = 1'b1;
    bit take_gaps = 1'b1;
    int stall_cycles = 0;

    logic signed [FIELD_W-1:0] recent [8];
    int                        recent_idx = 0;

    fwsr_cmd_if cmd_ch ();
    fwsr_rsp_if rsp_ch ();

    fifo_with_swap_reverse_search i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    fwsr_scoreboard i_scoreboard
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .drain_done  (drain_done),
        .cmd         (cmd_ch),
        .rsp         (rsp_ch),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one request and hold it until accepted
    task automatic issue_request(logic [ACTION_W-1:0] act, logic signed [FIELD_W-1:0] val);
        if (send_gaps && $urandom_range(0, 4) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.action <= act;
        cmd_ch.value  <= val;
        if (act == ACT_ENQ)
        begin
            recent[recent_idx] = val;
            recent_idx = (recent_idx + 1) % 8;
        end
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    // extremes, a few repeating small words, otherwise anything
    function automatic logic signed [FIELD_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
        begin
            case ($urandom_range(0, 3))
                0: return 32'sh8000_0000;
                1: return 32'sh7fff_ffff;
                2: return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        else if (r <= 3)
        begin
            return FIELD_W'($signed($urandom_range(0, 7)) - 4);
        end
        return $urandom;
    endfunction

    // action mix leaning towards filling, draining or neither
    function automatic logic [ACTION_W-1:0] pick_action(int bias);
        int r;
        int enq_w;
        int deq_w;
        r     = $urandom_range(0, 99);
        enq_w = (bias == 0) ? 50 : (bias == 1) ? 15 : 30;
        deq_w = (bias == 0) ? 15 : (bias == 1) ? 50 : 30;
        if (r < enq_w)
        begin
            return ACT_ENQ;
        end
        else if (r < enq_w + deq_w)
        begin
            return ACT_DEQ;
        end
        else if (r < enq_w + deq_w + 10)
        begin
            return ACT_SWAP;
        end
        else if (r < enq_w + deq_w + 17)
        begin
            return ACT_REV;
        end
        else if (r < 97)
        begin
            return ACT_SEARCH;
        end
        else if (r == 97)
        begin
            return ACT_CLEAR;
        end
        return $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
    endfunction

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_cycles > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall_cycles) @(posedge clk);
                stall_cycles = 0;
                rsp_ch.ready <= 1'b1;
            end
            else if (take_gaps && $urandom_range(0, 6) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                rsp_ch.ready <= 1'b1;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        logic [ACTION_W-1:0]       act;
        logic signed [FIELD_W-1:0] val;
        int                        fill_bias;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.action <= ACT_ENQ;
        cmd_ch.value  <= '0;
        for (int i = 0; i < 8; i++)
        begin
            recent[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty-queue errors, extremes, single- and two-entry swap, search, reverse, no-op codes and clear
        issue_request(ACT_DEQ, 32'sd0);
        issue_request(ACT_SWAP, 32'sd0);
        issue_request(ACT_SEARCH, 32'sd0);
        issue_request(ACT_ENQ, 32'sh8000_0000);
        issue_request(ACT_SWAP, 32'sd0);
        issue_request(ACT_ENQ, 32'sh7fff_ffff);
        issue_request(ACT_SWAP, 32'sd0);
        issue_request(ACT_SEARCH, 32'sh8000_0000);
        issue_request(ACT_SEARCH, 32'sd1);
        issue_request(ACT_REV, 32'sd0);
        issue_request(ACT_ENQ, 32'sh5555_5555);
        issue_request(ACT_ENQ, 32'shaaaa_aaaa);
        issue_request(ACT_DEQ, 32'sd0);
        issue_request(ACT_SPARE_A, 32'shffff_ffff);
        issue_request(ACT_SPARE_B, 32'sh1234_5678);
        issue_request(ACT_CLEAR, 32'sd0);

        // hold the result side for a long stretch and fill the queue past full
        stall_cycles = 80;
        for (int n = 0; n < 20; n++)
        begin
            issue_request(ACT_ENQ, pick_value());
        end
        issue_request(ACT_REV, 32'sd0);

        // random mix in segments of varying bias and idling
        fill_bias = 2;
        for (int n = 0; n < 1000; n++)
        begin
            if (n % 40 == 0)
            begin
                fill_bias = $urandom_range(0, 2);
                send_gaps = (n < 900) && ($urandom_range(0, 2) != 0);
                take_gaps = (n < 900) && ($urandom_range(0, 2) != 0);
            end
            act = pick_action(fill_bias);
            if (act == ACT_SEARCH && $urandom_range(0, 1) == 1)
            begin
                val = recent[$urandom_range(0, 7)];
            end
            else
            begin
                val = pick_value();
            end
            issue_request(act, val);
        end
        cmd_ch.valid <= 1'b0;

        // drain, then allow for the longest search
        for (int n = 0; n < 5000 && outstanding != 0; n++)
        begin
            @(posedge clk);
        end
        repeat (40) @(posedge clk);
        drain_done = 1'b1;
        @(posedge clk);
        if (fail_count == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: fifo_with_swap_reverse_search.f
hw/rtl/fwsr_pkg.sv
hw/rtl/fwsr_cmd_if.sv
hw/rtl/fwsr_rsp_if.sv
hw/rtl/fwsr_store.sv
hw/rtl/fwsr_ctrl.sv
hw/rtl/fifo_with_swap_reverse_search.sv
hw/rtl/fwsr_check.sv
verif/fwsr_scoreboard.sv
verif/testbench.sv
